// ===== src/tci_pkg.sv =====
// Shared types and constants for the table cubic interpolator.
package tci_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam int unsigned Stencil           = 4;
  localparam int unsigned DataW             = 32;
  localparam int unsigned LenW              = 9;

  // Configuration register indexes.
  localparam logic [0:0] CfgTableLength = 1'b0;
  localparam logic [0:0] CfgThreshold   = 1'b1;

  // Input word kinds.
  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoSegment = 2'd1;
  localparam logic [1:0] StatusShort     = 2'd2;

  localparam logic [LenW-1:0]  LenReset       = 9'd4;
  localparam logic [DataW-1:0] ThresholdReset = 32'h0200_0000;

  // Request handed to the Neville step unit.
  typedef struct packed {
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [DataW-1:0] xi;
    logic signed [DataW-1:0] xj;
    logic signed [DataW-1:0] q;
  } nev_req_t;

endpackage

// ===== src/tci_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tci_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/tci_nev.sv =====
// Multi-cycle Neville step: b + round((q-xj)(a-b)/(xi-xj)), saturated.
module tci_nev (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tci_pkg::nev_req_t req_i,
  output logic              done_o,
  output logic signed [31:0] res_o
);
  import tci_pkg::*;

  typedef enum logic [1:0] {NIdle, NMul, NDiv, NFin} nstate_e;

  nstate_e            state_q;
  logic signed [32:0] d_q, u_q, w_q;
  logic signed [31:0] a_q, b_q;
  logic [63:0]        prod_q;
  logic [32:0]        dm_q;
  logic [65:0]        num_q;   // dividend shift register
  logic [33:0]        rem_q;
  logic [65:0]        quo_q;
  logic [6:0]         cnt_q;
  logic               neg_q;

  logic [32:0] um, wm, dm;
  logic [34:0] trial;
  logic signed [35:0] sum;   // b +/- quotient, quotient up to 2^34
  logic [33:0] rem_sh;

  assign um = u_q[32] ? 33'(-u_q) : 33'(u_q);
  assign wm = w_q[32] ? 33'(-w_q) : 33'(w_q);
  assign dm = d_q[32] ? 33'(-d_q) : 33'(d_q);
  assign rem_sh = {rem_q[32:0], num_q[65]};
  assign trial = {1'b0, rem_sh} - {2'b0, dm_q};
  assign sum = neg_q ? 36'(b_q) - 36'(quo_q[34:0]) : 36'(b_q) + 36'(quo_q[34:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NIdle;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        NIdle: begin
          if (start_i) begin
            d_q <= 33'(req_i.xi) - 33'(req_i.xj);
            u_q <= 33'(req_i.q) - 33'(req_i.xj);
            w_q <= 33'(req_i.a) - 33'(req_i.b);
            a_q <= req_i.a;
            b_q <= req_i.b;
            state_q <= NMul;
          end
        end
        NMul: begin
          if (d_q == '0) begin
            res_o <= a_q; done_o <= 1'b1; state_q <= NIdle;
          end else if (u_q == '0 || w_q == '0) begin
            res_o <= b_q; done_o <= 1'b1; state_q <= NIdle;
          end else begin
            neg_q  <= (u_q[32] ^ w_q[32]) ^ d_q[32];
            prod_q <= 64'(um * wm);
            dm_q   <= dm;
            num_q  <= '0;
            cnt_q  <= '0;
            state_q <= NDiv;
          end
        end
        NDiv: begin
          if (cnt_q == '0 && num_q == '0) begin
            num_q <= {1'b0, 65'(prod_q) + 65'(dm_q >> 1)};
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= 7'd1;
          end else begin
            if (!trial[34]) begin
              rem_q <= trial[33:0];
              quo_q <= {quo_q[64:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[64:0], 1'b0};
            end
            num_q <= {num_q[64:0], 1'b0};
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == 7'd66) state_q <= NFin;
          end
        end
        NFin: begin
          if (quo_q > 66'(64'h4_0000_0000)) begin
            res_o <= neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else if (sum > 36'sh0_7fff_ffff) begin
            res_o <= 32'sh7fff_ffff;
          end else if (sum < -36'sh0_8000_0000) begin
            res_o <= 32'sh8000_0000;
          end else begin
            res_o <= sum[31:0];
          end
          done_o  <= 1'b1;
          state_q <= NIdle;
        end
        default: state_q <= NIdle;
      endcase
    end
  end
endmodule

// ===== src/table_cubic_interpolator.sv =====
// Top level of the table cubic interpolator.
// Usage:
//  - s_axis: input words. tuser = kind (0 load, 1 query). tdata from bit 0:
//    entry_index[7:0], entry_key[39:8], entry_value[71:40], query_key[103:72].
//  - m_axis: one result word per query; tdata = interpolated[31:0],
//    status[33:32], padded to 40 bits. Loads give no result.
//  - cfg: index 0 table_length, index 1 linear_fallback_threshold.
// Flow: a load writes both tables in SLoad. A query scans the key RAM one
//  entry at a time, reads the 4-point stencil, then runs one Neville step
//  (linear fallback) or six (cubic) on a shared unit built on a bit-serial
//  divider; a short table or a key with no segment gets none.
//  s_axis_tready is low while a word is in work.
// Reset clears control state and configuration; the tables stay unknown
//  until loaded. A stalled receiver holds the result in the output register;
//  no new word is taken until it is delivered.
module table_cubic_interpolator
  import tci_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // entry_index, entry_key, entry_value, query_key
  input  logic [0:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // interpolated, status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  localparam int unsigned AW = $clog2(TableDepth);

  typedef enum logic [3:0] {
    SIdle, SLoad, SScan, SScanChk, SRead, SRdWait, SRdTake, SPick, SNevGo,
    SNevWait, SOut
  } state_e;

  state_e state_q;
  logic [LenW-1:0] len_q;
  logic signed [31:0] thr_q;
  logic [7:0]  idx_q;
  logic signed [31:0] ekey_q, eval_q, q_q;
  logic [12:0] j_q;     // scan / stencil counter
  logic [2:0]  k_q;
  logic signed [31:0] x_q [Stencil];
  logic signed [31:0] p_q [Stencil];
  logic [1:0]  m_q, nk_q;
  logic        lin_q;
  logic [12:0] n;
  logic [31:0] key_rd, val_rd;
  logic [AW-1:0] raddr;
  logic        we;
  logic        nev_start, nev_done;
  logic signed [31:0] nev_res;
  nev_req_t    req;
  logic signed [31:0] res_q;
  logic [1:0]  status_q;
  logic signed [32:0] vmin, vmax;
  logic [12:0] bstart;

  assign n = (13'(len_q) > 13'(TableDepth)) ? 13'(TableDepth) : 13'(len_q);
  assign s_axis_tready = (state_q == SIdle);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata = {6'd0, status_q, res_q};
  assign we = (state_q == SLoad) && (32'(idx_q) < 32'(TableDepth));
  assign raddr = AW'(j_q);

  tci_ram #(.Width(32), .Depth(TableDepth)) u_keys (
    .clk_i, .we_i(we), .waddr_i(AW'(idx_q)), .wdata_i(ekey_q),
    .raddr_i(raddr), .rdata_o(key_rd));
  tci_ram #(.Width(32), .Depth(TableDepth)) u_vals (
    .clk_i, .we_i(we), .waddr_i(AW'(idx_q)), .wdata_i(eval_q),
    .raddr_i(raddr), .rdata_o(val_rd));

  tci_nev u_nev (.clk_i, .rst_ni, .start_i(nev_start), .req_i(req),
    .done_o(nev_done), .res_o(nev_res));

  assign nev_start = (state_q == SNevGo);
  assign req = '{a:  p_q[nk_q],
                 b:  p_q[nk_q + 2'd1],
                 xi: x_q[nk_q],
                 xj: x_q[nk_q + m_q],
                 q:  q_q};

  always_comb begin
    vmin = 33'(p_q[0]);
    vmax = 33'(p_q[0]);
    for (int i = 1; i < Stencil; i++) begin
      if (33'(p_q[i]) < vmin) vmin = 33'(p_q[i]);
      if (33'(p_q[i]) > vmax) vmax = 33'(p_q[i]);
    end
  end

  // Bracket j-1 gives stencil start j-3, clamped to [0, n-4].
  assign bstart = (j_q < 13'd3) ? 13'd0 :
                  ((j_q - 13'd3) > (n - 13'd4)) ? n - 13'd4 : j_q - 13'd3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      len_q   <= LenReset;
      thr_q   <= ThresholdReset;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgTableLength) len_q <= cfg_data_i[LenW-1:0];
        else thr_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (s_axis_tvalid) begin
            idx_q  <= s_axis_tdata[7:0];
            ekey_q <= s_axis_tdata[39:8];
            eval_q <= s_axis_tdata[71:40];
            q_q    <= s_axis_tdata[103:72];
            j_q    <= '0;
            if (s_axis_tuser[0] == KindLoad) state_q <= SLoad;
            else state_q <= SScan;
          end
        end
        SLoad: state_q <= SIdle;
        SScan: begin
          if (n < 13'(Stencil)) begin
            res_q <= '0; status_q <= StatusShort; state_q <= SOut;
          end else begin
            state_q <= SScanChk;  // RAM read of entry j in flight
          end
        end
        SScanChk: begin
          if ($signed(key_rd) > q_q) begin
            j_q <= bstart; k_q <= '0; state_q <= SRdWait;
          end else if (j_q + 13'd1 >= n) begin
            j_q <= n - 13'd4; k_q <= '0; state_q <= SRdWait;
          end else begin
            j_q <= j_q + 13'd1;
            state_q <= SScan;
          end
        end
        SRdWait: state_q <= SRdTake;
        SRdTake: begin
          x_q[k_q[1:0]] <= key_rd;
          p_q[k_q[1:0]] <= val_rd;
          if (k_q == 3'd3) begin
            state_q <= SPick;
          end else begin
            k_q <= k_q + 3'd1; j_q <= j_q + 13'd1; state_q <= SRdWait;
          end
        end
        SPick: begin
          status_q <= StatusOk;
          if (vmax - vmin > 33'(thr_q)) begin
            lin_q <= 1'b1; m_q <= 2'd1;
            if (x_q[0] <= q_q && q_q <= x_q[1]) begin
              nk_q <= 2'd0; state_q <= SNevGo;
            end else if (x_q[1] <= q_q && q_q <= x_q[2]) begin
              nk_q <= 2'd1; state_q <= SNevGo;
            end else if (x_q[2] <= q_q && q_q <= x_q[3]) begin
              nk_q <= 2'd2; state_q <= SNevGo;
            end else begin
              res_q <= '0; status_q <= StatusNoSegment; state_q <= SOut;
            end
          end else begin
            lin_q <= 1'b0; m_q <= 2'd1; nk_q <= 2'd0; state_q <= SNevGo;
          end
        end
        SNevGo: state_q <= SNevWait;
        SNevWait: begin
          if (nev_done) begin
            if (lin_q) begin
              res_q <= nev_res; state_q <= SOut;
            end else begin
              p_q[nk_q] <= nev_res;
              if (32'(nk_q) + 32'(m_q) >= 32'(Stencil) - 1) begin
                if (m_q == 2'd3) begin
                  res_q <= nev_res; state_q <= SOut;
                end else begin
                  m_q <= m_q + 2'd1; nk_q <= 2'd0; state_q <= SNevGo;
                end
              end else begin
                nk_q <= nk_q + 2'd1; state_q <= SNevGo;
              end
            end
          end
        end
        SOut: if (m_axis_tready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== src/tci_checker.sv =====
// Port-level checker for the table cubic interpolator, bound to the top.
module tci_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);
  // A held result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // No input taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted with result pending");
  // Status never takes the unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
    else $error("bad status");
  // An accepted word leaves the input side busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready stayed high after accept");
endmodule

bind table_cubic_interpolator tci_checker u_tci_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the table cubic interpolator.
`timescale 1ns / 1ps

module tb;
  import tci_pkg::*;

  localparam int unsigned Depth      = TableDepthDefault;
  localparam int unsigned StallLimit = 6000;  // idle cycles before the watchdog trips
  localparam int unsigned RandItems  = 750;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // entry_index, entry_key, entry_value, query_key
  logic [0:0]   s_axis_tuser = '0;  // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;       // interpolated, status
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [0:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  table_cubic_interpolator u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: shadow of table and registers.
  longint      key_tab [Depth];
  longint      val_tab [Depth];
  logic [8:0]  tab_len;
  longint      fallback_thr;

  typedef struct {
    logic signed [31:0] interp;
    logic [1:0]         status;
  } result_t;
  result_t result_q[$];

  int unsigned send_idle, recv_idle, errors, stall_cnt;

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // One Neville combination: b + round((q - xj)(a - b) / (xi - xj)), ties away from zero.
  function automatic longint neville_step(input longint a, b, xi, xj, q);
    longint d = xi - xj;
    longint u = q - xj;
    longint w = a - b;
    longint unsigned dm, prod, quo;
    bit neg;
    if (d == 0) return a;
    if (u == 0 || w == 0) return b;
    neg  = ((u < 0) != (w < 0)) != (d < 0);
    dm   = (d < 0) ? -d : d;
    prod = longint'((u < 0) ? -u : u) * longint'((w < 0) ? -w : w);
    quo  = (prod + dm / 2) / dm;
    if (quo > (64'd1 << 34)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    return longint'(clip32(neg ? b - longint'(quo) : b + longint'(quo)));
  endfunction

  function automatic result_t interpolate_at(input longint qk);
    result_t r;
    longint n, start;
    longint x[4], y[4], p[4], vmin, vmax;
    bit found, seg;
    r.interp = '0;
    r.status = StatusOk;
    n = (tab_len > Depth) ? Depth : tab_len;
    if (n < Stencil) begin
      r.status = StatusShort;
      return r;
    end
    found = 1'b0;
    start = n - Stencil;  // key above table: last stencil
    for (int j = 0; j < n; j++) begin
      if (!found && key_tab[j] > qk) begin
        found = 1'b1;
        start = j - 3;  // bracket j-1, stencil two below it
        if (start < 0) start = 0;
        if (start > n - Stencil) start = n - Stencil;
      end
    end
    for (int k = 0; k < 4; k++) begin
      x[k] = key_tab[start + k];
      y[k] = val_tab[start + k];
    end
    vmin = y[0];
    vmax = y[0];
    for (int k = 1; k < 4; k++) begin
      if (y[k] < vmin) vmin = y[k];
      if (y[k] > vmax) vmax = y[k];
    end
    if (vmax - vmin > fallback_thr) begin
      seg = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (!seg && x[k] <= qk && qk <= x[k+1]) begin
          r.interp = neville_step(y[k], y[k+1], x[k], x[k+1], qk);
          seg = 1'b1;
        end
      end
      if (!seg) r.status = StatusNoSegment;
    end else begin
      for (int k = 0; k < 4; k++) p[k] = y[k];
      for (int m = 1; m < 4; m++)
        for (int k = 0; k + m < 4; k++)
          p[k] = neville_step(p[k], p[k+1], x[k], x[k+m], qk);
      r.interp = p[0];
    end
    return r;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (m_axis_tdata[31:0] !== e.interp) begin
          $error("interpolated: expected %h, got %h", e.interp, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[33:32] !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tdata[33:32]);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Drives one input word; on acceptance updates the shadow table or queues a result.
  task automatic send_word(input logic kind, input logic [7:0] idx,
                           input logic [31:0] key, val, qk,
                           input bit typed = 0, input result_t typed_res = '{0, 0});
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {qk, val, key, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == KindLoad) begin
      key_tab[idx] = longint'(signed'(key));
      val_tab[idx] = longint'(signed'(val));
    end else begin
      result_q.push_back(typed ? typed_res : interpolate_at(longint'(signed'(qk))));
    end
  endtask

  // Register write, only once the block has gone quiet.
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (result_q.size() == 0);
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgTableLength) tab_len = data[8:0];
    else fallback_thr = longint'(signed'(data));
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  typedef enum {ActLoad, ActQuery, ActReg} act_e;
  typedef struct {
    act_e        act;
    logic [7:0]  idx;     // slot, or register index
    logic [31:0] key;     // entry key, query key, or register data
    logic [31:0] val;
    bit          typed;   // expectation written out below
    result_t     res;
  } row_t;

  localparam int NumRows = 23;
  row_t dir_rows [NumRows] = '{
    // too-short table
    '{ActReg,   CfgTableLength, 32'd3,         0,             0, '{0, 0}},
    '{ActQuery, 0,              32'h0000_0000, 0,             1, '{0, StatusShort}},
    '{ActQuery, 0,              32'h8000_0000, 0,             1, '{0, StatusShort}},
    '{ActReg,   CfgTableLength, 32'd4,         0,             0, '{0, 0}},
    // smooth four-point table: keys -2, -1, 1, 2
    '{ActLoad,  0,              32'hFE00_0000, 32'h0000_0000, 0, '{0, 0}},
    '{ActLoad,  1,              32'hFF00_0000, 32'h0080_0000, 0, '{0, 0}},
    '{ActLoad,  2,              32'h0100_0000, 32'h0100_0000, 0, '{0, 0}},
    '{ActLoad,  3,              32'h0200_0000, 32'h0180_0000, 0, '{0, 0}},
    '{ActQuery, 0,              32'h0000_0000, 0,             0, '{0, 0}},
    '{ActQuery, 0,              32'h7FFF_FFFF, 0,             0, '{0, 0}},
    '{ActQuery, 0,              32'h8000_0000, 0,             0, '{0, 0}},
    '{ActQuery, 0,              32'h0100_0000, 0,             0, '{0, 0}},
    // negative threshold forces the line; off-table keys find no segment
    '{ActReg,   CfgThreshold,   32'h8000_0000, 0,             0, '{0, 0}},
    '{ActQuery, 0,              32'h8000_0000, 0,             1, '{0, StatusNoSegment}},
    '{ActQuery, 0,              32'h7FFF_FFFF, 0,             1, '{0, StatusNoSegment}},
    '{ActQuery, 0,              32'h0040_0000, 0,             0, '{0, 0}},
    // equal keys and extreme values through the cubic, then the line
    '{ActReg,   CfgThreshold,   32'h7FFF_FFFF, 0,             0, '{0, 0}},
    '{ActLoad,  2,              32'hFF00_0000, 32'h7FFF_FFFF, 0, '{0, 0}},
    '{ActQuery, 0,              32'h0040_0000, 0,             0, '{0, 0}},
    '{ActLoad,  0,              32'hFE00_0000, 32'h8000_0000, 0, '{0, 0}},
    '{ActQuery, 0,              32'h7FFF_FFFF, 0,             0, '{0, 0}},
    '{ActReg,   CfgThreshold,   32'h0200_0000, 0,             0, '{0, 0}},
    '{ActQuery, 0,              32'hFF00_0000, 0,             0, '{0, 0}}
  };

  initial begin
    int unsigned sent, nfill, lens[7], thrs[8];
    longint step, base, v0, slope, v, lo, hi, qk;
    int vmode, phase;
    logic [7:0] slot;
    tab_len      = LenReset;
    fallback_thr = longint'(signed'(ThresholdReset));
    for (int i = 0; i < Depth; i++) begin
      key_tab[i] = 0;
      val_tab[i] = 0;
    end
    send_idle = 10;
    recv_idle = 80;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      case (dir_rows[r].act)
        ActReg:   write_reg(dir_rows[r].idx[0], dir_rows[r].key);
        ActLoad:  send_word(KindLoad, dir_rows[r].idx, dir_rows[r].key, dir_rows[r].val,
                            $urandom);
        default:  send_word(KindQuery, 8'($urandom), $urandom, $urandom, dir_rows[r].key,
                            dir_rows[r].typed, dir_rows[r].res);
      endcase
    end

    // Random phases: new settings, a fresh table, then mixed queries and loads.
    lens = '{256, 511, 4, 5, 9, 17, 40};
    thrs = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h0200_0000,
             32'h0010_0000, 32'h0800_0000, 0};
    sent  = 0;
    phase = 0;
    while (sent < RandItems) begin
      if (sent >= 500) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (sent >= 250) begin
        send_idle = 80;
        recv_idle = 10;
      end
      write_reg(CfgTableLength,
                (phase < 2) ? lens[phase] : lens[2 + $urandom_range(4)]);
      thrs[7] = $urandom;
      write_reg(CfgThreshold, (phase < 2) ? thrs[phase] : thrs[$urandom_range(7)]);
      nfill = (tab_len > Depth) ? Depth : tab_len;
      step  = $urandom_range(1, 32'h7FFF_FFFF / nfill);
      base  = -(step * nfill / 2) + $urandom_range(0, step);
      vmode = $urandom_range(7);
      v0    = longint'($urandom_range(0, 32'h2000_0000)) - 64'sh1000_0000;
      slope = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
      for (int i = 0; i < nfill; i++) begin
        v = (vmode < 5) ? v0 + i * slope + $urandom_range(0, 32'h1_0000) - 32'h8000
                        : longint'(signed'($urandom));
        send_word(KindLoad, 8'(i), (vmode == 7) ? $urandom : 32'(base + i * step),
                  clip32(v), $urandom);
        sent++;
      end
      lo = base - step;
      hi = base + step * nfill;
      for (int t = $urandom_range(20, 45); t > 0; t--) begin
        case ($urandom_range(19))
          0, 1: begin  // retouch a value in use, key kept
            slot = 8'($urandom_range(0, nfill - 1));
            send_word(KindLoad, slot, 32'(key_tab[slot]), $urandom, $urandom);
          end
          2: begin     // anything at all
            slot = 8'($urandom);
            send_word(KindLoad, slot, $urandom, $urandom, $urandom);
          end
          3: send_word(KindQuery, 8'($urandom), $urandom, $urandom, $urandom);
          4: send_word(KindQuery, 8'($urandom), $urandom, $urandom,
                       32'(key_tab[$urandom_range(0, nfill - 1)]));
          5: send_word(KindQuery, 8'($urandom), $urandom, $urandom,
                       $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
          default: begin
            qk = lo + longint'((longint'($urandom) * (hi - lo)) >>> 32);
            send_word(KindQuery, 8'($urandom), $urandom, $urandom, clip32(qk));
          end
        endcase
        sent++;
      end
      if (phase == 3) begin  // hold off until the block has drained
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        wait (result_q.size() == 0);
      end
      phase++;
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (result_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tci_pkg.sv
src/tci_ram.sv
src/tci_nev.sv
src/table_cubic_interpolator.sv
src/tci_checker.sv
sim/tb.sv
